/* design/cfq_pkg.sv */
package cfq_pkg;

    localparam int DEPTH_DEFAULT = 8;
    localparam int DATA_W        = 32;

    typedef enum logic [1:0] {
        FUNC_ENQ  = 2'd0,
        FUNC_DEQ  = 2'd1,
        FUNC_DISP = 2'd2
    } func_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2,
        ST_EMPTY     = 2'd3
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EMIT = 1'b1
    } state_t;

    typedef struct packed {
        logic accept;
        logic emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic empty;
        logic rem_one;
        logic out_free;
    } dp_status_t;

endpackage

/* design/cfq_ctrl.sv */
module cfq_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  cfq_pkg::func_t     func,
    input  cfq_pkg::dp_status_t dp_status,
    output cfq_pkg::ctrl_cmd_t cmd
);
    import cfq_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_tready = dp_status.out_free;
                if (s_tvalid && dp_status.out_free) begin
                    cmd.accept = 1'b1;
                    if ((func == FUNC_DEQ || func == FUNC_DISP) && !dp_status.empty) begin
                        state_next = S_EMIT;
                    end
                end
            end
            S_EMIT: begin
                if (dp_status.out_free) begin
                    cmd.emit = 1'b1;
                    if (dp_status.rem_one) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

/* design/cfq_dpath.sv */
module cfq_dpath #(
    parameter int DEPTH = cfq_pkg::DEPTH_DEFAULT
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  cfq_pkg::func_t              func,
    input  logic [cfq_pkg::DATA_W-1:0]  value,
    input  cfq_pkg::ctrl_cmd_t          cmd,
    output cfq_pkg::dp_status_t         dp_status,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [cfq_pkg::DATA_W-1:0]  m_tdata,
    output logic [1:0]                  m_tuser,
    output logic                        m_tlast
);
    import cfq_pkg::*;

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam logic [ADDR_W-1:0] ADDR_MAX = ADDR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0]  CNT_FULL = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0]  CNT_ONE  = CNT_W'(1);

    function automatic logic [ADDR_W-1:0] advance(input logic [ADDR_W-1:0] idx);
        return (idx == ADDR_MAX) ? '0 : idx + ADDR_W'(1);
    endfunction

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    logic [ADDR_W-1:0] head_reg, head_next;
    logic [ADDR_W-1:0] tail_reg, tail_next;
    logic [ADDR_W-1:0] pos_reg, pos_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;

    logic              m_valid_reg, m_valid_next;
    status_t           m_status_reg, m_status_next;
    logic [DATA_W-1:0] m_data_reg, m_data_next;
    logic              m_last_reg, m_last_next;

    logic              wr_en;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              empty;
    logic              full;
    logic              out_free;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == CNT_FULL);
    assign out_free = !m_valid_reg || m_tready;

    assign dp_status.empty    = empty;
    assign dp_status.rem_one  = (rem_reg == CNT_ONE);
    assign dp_status.out_free = out_free;

    assign wr_en   = cmd.accept && (func == FUNC_ENQ) && !full;
    assign rd_en   = cmd.accept || cmd.emit;
    assign rd_addr = cmd.accept ? head_reg : pos_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[tail_reg] <= value;
        end
        if (rd_en) begin
            rdata_reg <= mem_reg[rd_addr];
        end
    end

    always_comb begin
        head_next     = head_reg;
        tail_next     = tail_reg;
        pos_next      = pos_reg;
        count_next    = count_reg;
        rem_next      = rem_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_status_next = m_status_reg;
        m_data_next   = m_data_reg;
        m_last_next   = m_last_reg;

        if (cmd.accept) begin
            case (func)
                FUNC_ENQ: begin
                    m_valid_next  = 1'b1;
                    m_data_next   = '0;
                    m_last_next   = 1'b1;
                    if (full) begin
                        m_status_next = ST_OVERFLOW;
                    end else begin
                        m_status_next = ST_OK;
                        tail_next     = advance(tail_reg);
                        count_next    = count_reg + CNT_ONE;
                    end
                end
                FUNC_DEQ: begin
                    if (empty) begin
                        m_valid_next  = 1'b1;
                        m_status_next = ST_UNDERFLOW;
                        m_data_next   = '0;
                        m_last_next   = 1'b1;
                    end else begin
                        head_next  = advance(head_reg);
                        count_next = count_reg - CNT_ONE;
                        rem_next   = CNT_ONE;
                        pos_next   = advance(head_reg);
                    end
                end
                FUNC_DISP: begin
                    if (empty) begin
                        m_valid_next  = 1'b1;
                        m_status_next = ST_EMPTY;
                        m_data_next   = '0;
                        m_last_next   = 1'b1;
                    end else begin
                        rem_next = count_reg;
                        pos_next = advance(head_reg);
                    end
                end
                default: begin
                end
            endcase
        end else if (cmd.emit) begin
            m_valid_next  = 1'b1;
            m_status_next = ST_OK;
            m_data_next   = rdata_reg;
            m_last_next   = (rem_reg == CNT_ONE);
            rem_next      = rem_reg - CNT_ONE;
            pos_next      = advance(pos_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg    <= '0;
            tail_reg    <= '0;
            count_reg   <= '0;
            rem_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            count_reg   <= count_next;
            rem_reg     <= rem_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg      <= pos_next;
        m_status_reg <= m_status_next;
        m_data_reg   <= m_data_next;
        m_last_reg   <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_status_reg;
    assign m_tlast  = m_last_reg;

endmodule

/* design/circular_fifo_queue.sv */
// Circular FIFO of signed 32-bit words, DEPTH entries deep.
// Input stream: s_tuser selects the request (enqueue, dequeue, display),
// s_tdata carries the word to enqueue. Output stream: m_tuser is the status
// (ok, overflow, underflow, empty display), m_tdata the dequeued or displayed
// word, m_tlast marks the final result of a request.
// Enqueue, overflow, underflow and empty display: one result, registered
// in the cycle after the item is taken; a new item can be taken every cycle.
// Dequeue: one result after the registered memory read, intake busy until
// it is out. Display of n stored words: n results, one per cycle while
// m_tready is high, intake busy to the last; the single read port sets this.
// A result waits in the output register while m_tready is low; the next item
// is taken only once that register can be loaded, so a stalled receiver
// stalls intake and nothing is dropped.
// Reset (aresetn low, synchronous) empties the queue and drops any pending
// result; entry contents are not cleared and need no clearing pass.
module circular_fifo_queue #(
    parameter int DEPTH = cfq_pkg::DEPTH_DEFAULT
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [cfq_pkg::DATA_W-1:0] s_tdata,   // [31:0] value
    input  logic [1:0]                 s_tuser,   // [1:0] func
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [cfq_pkg::DATA_W-1:0] m_tdata,   // [31:0] data
    output logic [1:0]                 m_tuser,   // [1:0] status
    output logic                       m_tlast
);
    import cfq_pkg::*;

    func_t      func;
    ctrl_cmd_t  cmd;
    dp_status_t dp_status;

    assign func = func_t'(s_tuser);

    cfq_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .func      (func),
        .dp_status (dp_status),
        .cmd       (cmd)
    );

    cfq_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .func      (func),
        .value     (s_tdata),
        .cmd       (cmd),
        .dp_status (dp_status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule
